// File: hw/rtl/bvh_pkg.sv
// Package for the hierarchy overlap walker: widths, word structs, walk states.
// No dependencies.
`default_nettype none
package bvh_pkg;
   localparam int unsigned NODES       = 1024;
   localparam int unsigned STACK_DEPTH = 128;
   localparam int unsigned MAX_HITS    = 64;
   localparam int unsigned NODE_W      = $clog2(NODES);
   localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
   localparam int unsigned HIT_W       = $clog2(MAX_HITS + 1);
   localparam int unsigned VISIT_W     = $clog2(2 * NODES + 2);
   localparam int unsigned VISIT_BUDGET = 2 * NODES + 1;
   localparam int unsigned QDEPTH      = 4;
   localparam int unsigned QPTR_W      = $clog2(QDEPTH);

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_QUERY = 1'b1;
   localparam logic [0:0] CSR_ROOT   = 1'b0;
   localparam logic [0:0] CSR_COUNT  = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [9:0]         node_slot;
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] lo_z;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
      logic signed [31:0] hi_z;
      logic               is_leaf;
      logic [9:0]         left_child;
      logic [9:0]         right_child;
      logic [15:0]        leaf_triangle;
   } req_type;

   typedef struct packed {
      logic [15:0] triangle;
      logic        hit;
      logic        last;
      logic        truncated;
   } rsp_type;

   // Query box handed from the front queue to the walker.
   typedef struct packed {
      logic signed [31:0] lo_x;
      logic signed [31:0] lo_y;
      logic signed [31:0] lo_z;
      logic signed [31:0] hi_x;
      logic signed [31:0] hi_y;
      logic signed [31:0] hi_z;
   } qbox_type;

   typedef struct packed {
      logic [NODE_W-1:0] root;
      logic [NODE_W:0]   count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_START, ST_POP, ST_READ, ST_EVAL, ST_EMIT, ST_DONE
   } walk_state_type;
endpackage
`default_nettype wire

// File: hw/rtl/bvh_front.sv
// Front end: accepts request words, writes node table entries, queues queries.
// Depends on bvh_pkg.
`default_nettype none
module bvh_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bvh_pkg::req_type  req_data,
   input  wire logic              walk_busy,
   output logic                   wr_en,
   output bvh_pkg::req_type       wr_data,
   output logic                   q_valid,
   input  wire logic              q_take,
   output bvh_pkg::qbox_type      q_box
);
   bvh_pkg::qbox_type             fifo_ff [bvh_pkg::QDEPTH];
   logic [bvh_pkg::QPTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [bvh_pkg::QPTR_W:0]      cnt_ff, cnt_in;
   logic                          acc, push;

   // Hold any request while the queue is full, and a node write until every earlier query has finished its walk.
   assign req_stall = (cnt_ff == (bvh_pkg::QPTR_W+1)'(bvh_pkg::QDEPTH)) ||
                      (req_data.kind == bvh_pkg::KIND_WRITE && (cnt_ff != '0 || walk_busy));
   assign acc  = req_valid && !req_stall;
   assign push = acc && req_data.kind == bvh_pkg::KIND_QUERY;
   assign wr_en   = acc && req_data.kind == bvh_pkg::KIND_WRITE;
   assign wr_data = req_data;
   assign q_valid = cnt_ff != '0;
   assign q_box   = fifo_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_take ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (bvh_pkg::QPTR_W+1)'(push) - (bvh_pkg::QPTR_W+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= '{req_data.lo_x, req_data.lo_y, req_data.lo_z,
                             req_data.hi_x, req_data.hi_y, req_data.hi_z};
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/bvh_walk.sv
// Back end: node memory, walk stack and the traversal sequencer.
// Depends on bvh_pkg.
`default_nettype none
module bvh_walk (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bvh_pkg::cfg_type  cfg,
   input  wire logic              wr_en,
   input  wire bvh_pkg::req_type  wr_data,
   input  wire logic              q_valid,
   output logic                   q_take,
   input  wire bvh_pkg::qbox_type q_box,
   output logic                   walk_busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bvh_pkg::rsp_type       rsp_data
);
   localparam int unsigned NW = bvh_pkg::NODE_W;
   localparam int unsigned NODE_BITS = 6 * 32 + 1 + 2 * NW + 16;

   logic [NODE_BITS-1:0]    node_mem [bvh_pkg::NODES];
   logic [NODE_BITS-1:0]    node_rd_ff;
   logic [NW-1:0]           stk_mem [bvh_pkg::STACK_DEPTH];
   logic [NW-1:0]           stk_rd_ff;

   bvh_pkg::walk_state_type st_ff, st_in;
   bvh_pkg::qbox_type       box_ff;
   logic [bvh_pkg::SP_W-1:0]    sp_ff, sp_in;
   logic [bvh_pkg::HIT_W-1:0]   hits_ff, hits_in;
   logic [bvh_pkg::VISIT_W-1:0] vis_ff, vis_in;
   logic                    trunc_ff, trunc_in;
   logic [NW-1:0]           cur_ff, cur_in;
   logic                    cur_ok_ff, cur_ok_in;
   logic [15:0]             tri_ff, tri_in;    // held hit awaiting its successor
   logic                    pend_ff, pend_in;
   logic                    ov_ff, ov_in;
   bvh_pkg::rsp_type        out_ff, out_in;
   logic                    oval_ff, oval_in;

   // Node fields from the registered read word.
   logic signed [31:0] n_lox, n_loy, n_loz, n_hix, n_hiy, n_hiz;
   logic               n_leaf;
   logic [NW-1:0]      n_left, n_right;
   logic [15:0]        n_tri;
   assign {n_lox, n_loy, n_loz, n_hix, n_hiy, n_hiz, n_leaf, n_left, n_right, n_tri}
      = node_rd_ff;

   logic overlap, out_free, walk_more, stk_push2;
   logic [bvh_pkg::STK_AW-1:0] stk_wa;
   logic [NW-1:0] stk_wd;
   logic [bvh_pkg::SP_W-1:0] sp_dec;

   assign overlap = n_lox <= box_ff.hi_x && box_ff.lo_x <= n_hix &&
                    n_loy <= box_ff.hi_y && box_ff.lo_y <= n_hiy &&
                    n_loz <= box_ff.hi_z && box_ff.lo_z <= n_hiz;
   assign out_free  = !oval_ff || !rsp_stall;
   assign walk_more = sp_ff != '0 && hits_ff < bvh_pkg::HIT_W'(bvh_pkg::MAX_HITS)
                      && vis_ff < bvh_pkg::VISIT_W'(bvh_pkg::VISIT_BUDGET);
   assign sp_dec = sp_ff - 1'b1;
   assign walk_busy = st_ff != bvh_pkg::ST_IDLE;

   // Node memory: one write port from the front, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_data.node_slot[NW-1:0]] <= {wr_data.lo_x, wr_data.lo_y,
            wr_data.lo_z, wr_data.hi_x, wr_data.hi_y, wr_data.hi_z,
            wr_data.is_leaf, wr_data.left_child[NW-1:0],
            wr_data.right_child[NW-1:0], wr_data.leaf_triangle};
      end
      node_rd_ff <= node_mem[cur_in];
   end

   // Stack memory: the two children of a node are pushed one after the other (left in EVAL, right in POP with ov).
   always_ff @(posedge clock) begin
      if (stk_push2) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[sp_dec[bvh_pkg::STK_AW-1:0]];
   end

   always_comb begin
      unique case (st_ff)
         bvh_pkg::ST_IDLE:  st_in = q_valid ? bvh_pkg::ST_START : bvh_pkg::ST_IDLE;
         bvh_pkg::ST_START: st_in = bvh_pkg::ST_POP;
         bvh_pkg::ST_POP:   st_in = ov_ff ? bvh_pkg::ST_POP :
                                    (walk_more ? bvh_pkg::ST_READ : bvh_pkg::ST_DONE);
         bvh_pkg::ST_READ:  st_in = bvh_pkg::ST_EVAL;
         bvh_pkg::ST_EVAL:  st_in = (cur_ok_ff && overlap && n_leaf && pend_ff)
                                    ? bvh_pkg::ST_EMIT : bvh_pkg::ST_POP;
         bvh_pkg::ST_EMIT:  st_in = out_free ? bvh_pkg::ST_POP : bvh_pkg::ST_EMIT;
         bvh_pkg::ST_DONE:  st_in = out_free ? bvh_pkg::ST_IDLE : bvh_pkg::ST_DONE;
         default:           st_in = bvh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      sp_in = sp_ff; hits_in = hits_ff; vis_in = vis_ff; trunc_in = trunc_ff;
      cur_in = cur_ff; cur_ok_in = cur_ok_ff; tri_in = tri_ff; pend_in = pend_ff;
      ov_in = 1'b0; out_in = out_ff; q_take = 1'b0;
      stk_push2 = 1'b0; stk_wa = sp_ff[bvh_pkg::STK_AW-1:0]; stk_wd = n_left;
      oval_in = oval_ff && rsp_stall;
      unique case (st_ff)
         bvh_pkg::ST_IDLE: begin
            sp_in = '0; hits_in = '0; vis_in = '0; trunc_in = 1'b0; pend_in = 1'b0;
         end
         bvh_pkg::ST_START: begin
            q_take = 1'b1;
            if (cfg.count != '0 && {1'b0, cfg.root} < cfg.count) begin
               stk_push2 = 1'b1; stk_wa = '0; stk_wd = cfg.root;
               sp_in = bvh_pkg::SP_W'(1);
            end
         end
         bvh_pkg::ST_POP: begin
            if (ov_ff) begin
               // second push: right child sits above left
               stk_push2 = 1'b1; stk_wa = sp_ff[bvh_pkg::STK_AW-1:0]; stk_wd = n_right;
               sp_in = sp_ff + 1'b1;
            end else if (walk_more) begin
               sp_in = sp_dec;
               vis_in = vis_ff + 1'b1;
            end
         end
         bvh_pkg::ST_READ: begin
            cur_in = stk_rd_ff;
            cur_ok_in = {1'b0, stk_rd_ff} < cfg.count;
         end
         bvh_pkg::ST_EVAL: begin
            if (cur_ok_ff && overlap) begin
               if (n_leaf) begin
                  hits_in = hits_ff + 1'b1;
                  pend_in = 1'b1;
                  // an earlier held hit keeps its place until EMIT sends it
                  if (!pend_ff) tri_in = n_tri;
               end else if (32'(sp_ff) + 2 <= bvh_pkg::STACK_DEPTH) begin
                  stk_push2 = 1'b1; stk_wa = sp_ff[bvh_pkg::STK_AW-1:0]; stk_wd = n_left;
                  sp_in = sp_ff + 1'b1; ov_in = 1'b1;
               end else begin
                  trunc_in = 1'b1;
               end
            end
         end
         bvh_pkg::ST_EMIT: begin
            if (out_free) begin
               out_in = '{triangle: tri_ff, hit: 1'b1, last: 1'b0, truncated: 1'b0};
               oval_in = 1'b1;
               tri_in = n_tri;
            end
         end
         bvh_pkg::ST_DONE: begin
            if (out_free) begin
               out_in = '{triangle: pend_ff ? tri_ff : 16'd0, hit: pend_ff, last: 1'b1,
                          truncated: trunc_ff || sp_ff != '0};
               oval_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bvh_pkg::ST_IDLE; oval_ff <= 1'b0; sp_ff <= '0; hits_ff <= '0;
         vis_ff <= '0; trunc_ff <= 1'b0; pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; oval_ff <= oval_in; sp_ff <= sp_in; hits_ff <= hits_in;
         vis_ff <= vis_in; trunc_ff <= trunc_in; pend_ff <= pend_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == bvh_pkg::ST_IDLE && q_valid) box_ff <= q_box;
      cur_ff <= cur_in; cur_ok_ff <= cur_ok_in; tri_ff <= tri_in; out_ff <= out_in;
   end

   assign rsp_valid = oval_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

// File: hw/rtl/bvh_aabb_overlap_traversal.sv
// Top level of the hierarchy box-overlap walker: front end, query queue, walker.
// Depends on bvh_pkg, bvh_front, bvh_walk.
//
// Usage: req_ words carry either a node write (kind 0) or a box query (kind 1).
// A node write lands in the node memory in the cycle it is accepted and gives
// no response word. Queries wait in a four-deep queue in the front end so the
// sender can run ahead of the walker; a node write is held off (req_stall)
// while any query is queued or being walked, so it never overtakes one.
// The walker takes one query at a time from the root node in the root csr. A
// query passes through set-up and wind-down states, each stack pop goes through
// its pop, memory read and evaluate steps, an inner node that pushes its
// children adds a second push step, and each hit after the first adds an emit step.
// Each hit gives one rsp_ word; the final word carries last, and an empty
// query gives one word with hit low. A hit is held back one step so that the
// last flag rides on the final hit itself.
// Reset (synchronous, active high) empties the queue and stops any walk; the
// node memory is left as it was and entries must be written before use.
// When rsp_stall is high the output register holds its word and the walker
// waits; the front end keeps accepting queries until its queue fills.
// Write csr_ registers only while no query is in flight.
`default_nettype none
module bvh_aabb_overlap_traversal (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bvh_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bvh_pkg::rsp_type       rsp_data,
   input  wire logic              csr_write,
   input  wire logic [0:0]        csr_index,
   input  wire logic [10:0]       csr_data
);
   bvh_pkg::cfg_type  cfg_ff;
   bvh_pkg::req_type  wr_data;
   bvh_pkg::qbox_type q_box;
   logic              wr_en, q_valid, q_take, walk_busy;

   // Hold the configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            bvh_pkg::CSR_ROOT:  cfg_ff.root  <= csr_data[bvh_pkg::NODE_W-1:0];
            bvh_pkg::CSR_COUNT: cfg_ff.count <= csr_data[bvh_pkg::NODE_W:0];
            default: ;
         endcase
      end
   end

   bvh_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data, .walk_busy,
      .wr_en, .wr_data, .q_valid, .q_take, .q_box
   );

   bvh_walk u_walk (
      .clock, .reset, .cfg(cfg_ff), .wr_en, .wr_data, .q_valid, .q_take, .q_box,
      .walk_busy, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

// File: hw/rtl/bvh_checker.sv
// Port-level checks for the overlap walker, bound to the top level.
// Depends on bvh_pkg.
`default_nettype none
module bvh_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bvh_pkg::rsp_type rsp_data
);
   // Stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
   // A word without a hit is always the last of its query.
   a_nohit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.last)
      else $error("empty response not last");
   // Truncation is reported on the last word only.
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> rsp_data.last)
      else $error("truncated before last");
   // No response straight after reset.
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response out of reset");
endmodule

bind bvh_aabb_overlap_traversal bvh_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);
`default_nettype wire
